### rtl/core/bems_pkg.sv
package bems_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int U_DEPTH    = 2 * MAX_WIDTH + 1;
  localparam int V_DEPTH    = MAX_WIDTH + 1;
  localparam int UA_W       = $clog2(U_DEPTH);
  localparam int VA_W       = $clog2(V_DEPTH);
  localparam int POS_W      = $clog2(MAX_WIDTH);
  localparam int GEO_W      = 11;
  localparam int CFG_W      = 20;

  localparam logic [16:0] UNIT = 17'd32768;

  localparam logic [2:0] CFG_GRID_WIDTH       = 3'd0;
  localparam logic [2:0] CFG_GRID_HEIGHT      = 3'd1;
  localparam logic [2:0] CFG_THRESHOLD_OFFSET = 3'd2;
  localparam logic [2:0] CFG_THRESHOLD_SCALE  = 3'd3;
  localparam logic [2:0] CFG_REACTION_GAIN    = 3'd4;
  localparam logic [2:0] CFG_DIFFUSION_GAIN   = 3'd5;
  localparam logic [2:0] CFG_VERTICAL_WEIGHT  = 3'd6;
  localparam logic [2:0] CFG_RECOVERY_GAIN    = 3'd7;

  localparam logic [GEO_W-1:0] RST_GRID_WIDTH  = 11'd80;
  localparam logic [GEO_W-1:0] RST_GRID_HEIGHT = 11'd24;
  localparam logic [15:0]      RST_THR_OFFSET  = 16'd328;
  localparam logic [19:0]      RST_THR_SCALE   = 20'd87381;
  localparam logic [19:0]      RST_REACT_GAIN  = 20'd65536;
  localparam logic [19:0]      RST_DIFF_GAIN   = 20'd2621;
  localparam logic [19:0]      RST_VERT_WEIGHT = 20'd16384;
  localparam logic [19:0]      RST_RECOV_GAIN  = 20'd1311;

  localparam logic [3:0] STEP_LAST = 4'd12;

endpackage

### rtl/core/bems_ram.sv
module bems_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/core/barkley_excitable_medium_stencil_top.sv
// One explicit Euler step of the Barkley excitable medium over cells that arrive in raster
// order; the result for a cell leaves one row after it entered, and bubble items flush the
// last row. A new item is accepted only when the previous one has finished its last step; the
// steps are set by the single read port of the excitation line memory (four reads: center,
// west, east and north) and the one shared 24 by 24 multiplier that performs the seven
// products in turn. A finished result waits in the output register while the next item is
// accepted; while that register is still full and stalled, the item in its last step waits
// too. After reset and after every write of grid_width or grid_height the block clears all
// 1025 entries of the recovery memory before it takes an item.
module barkley_excitable_medium_stencil_top
  import bems_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             req_type_i,
  input  logic [15:0]      excite_in_i,
  input  logic [15:0]      recover_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [15:0]      excite_out_o,
  output logic [15:0]      recover_out_o,
  output logic             frame_last_o
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_BUSY} state_e;

  state_e            state_q;
  logic [3:0]        step_q;
  logic [VA_W-1:0]   clr_q;
  logic [GEO_W-1:0]  gw_q, gh_q;
  logic [15:0]       thr_off_q;
  logic [19:0]       thr_scale_q, react_gain_q, diff_gain_q, vert_wt_q, recov_gain_q;
  logic [UA_W-1:0]   u_ptr_q;
  logic [VA_W-1:0]   v_ptr_q;
  logic [POS_W-1:0]  col_q, row_q;
  logic [15:0]       uin_q, vin_q, v_q, c_q, wr_q, er_q;
  logic              bub_q, valid_q;
  logic signed [18:0] ew_q, ns_q;
  logic signed [27:0] th_q, p_q, lv_q, f_q, vd_q, react_q;
  logic signed [47:0] prod_q, prod_d;
  logic signed [23:0] ma, mb;
  logic              out_valid_q, frame_last_q;
  logic [15:0]       excite_out_q, recover_out_q;

  logic [GEO_W-1:0]  w_eff, h_eff, orow;
  logic [15:0]       u_sat, v_sat, west, east, north, south;
  logic [UA_W-1:0]   u_raddr;
  logic [VA_W-1:0]   v_raddr, v_waddr;
  logic [16:0]       v_wdata, v_rdata;
  logic [15:0]       u_rdata;
  logic              v_we, u_we, in_acc, out_free, geo_we, res_load;
  logic [UA_W:0]     back_k;
  logic signed [27:0] diff, u_sum, v_sum;
  logic [GEO_W:0]    vsum;

  function automatic logic signed [47:0] rshr(input logic signed [47:0] x, input logic sh16);
    logic [47:0] m;
    logic [47:0] r;
    m = x[47] ? 48'(-x) : 48'(x);
    r = sh16 ? ((m + 48'd32768) >> 16) : ((m + 48'd16384) >> 15);
    return x[47] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [15:0] clamp_unit(input logic signed [27:0] x);
    if (x < 0) begin
      return 16'd0;
    end else if (x > $signed({11'd0, UNIT})) begin
      return UNIT[15:0];
    end
    return x[15:0];
  endfunction

  assign w_eff = (gw_q < 11'd3) ? 11'd3 : (gw_q > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : gw_q;
  assign h_eff = (gh_q < 11'd2) ? 11'd2 : (gh_q > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : gh_q;
  assign orow  = (row_q == '0) ? h_eff - 11'd1 : {1'b0, row_q} - 11'd1;

  assign u_sat = (excite_in_i > UNIT[15:0]) ? UNIT[15:0] : excite_in_i;
  assign v_sat = (recover_in_i > UNIT[15:0]) ? UNIT[15:0] : recover_in_i;

  assign geo_we     = cfg_we_i && (cfg_idx_i == CFG_GRID_WIDTH || cfg_idx_i == CFG_GRID_HEIGHT);
  assign in_stall_o = (state_q != ST_IDLE) || geo_we;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign res_load   = (state_q == ST_BUSY) && (step_q == STEP_LAST) && out_free && valid_q
                      && !geo_we;

  always_comb begin
    logic [UA_W:0] t;
    case (step_q)
      4'd1:    back_k = {2'b0, w_eff};
      4'd2:    back_k = {2'b0, w_eff} + 13'd1;
      4'd3:    back_k = {2'b0, w_eff} - 13'd1;
      4'd4:    back_k = {1'b0, w_eff, 1'b0};
      default: back_k = '0;
    endcase
    t = {1'b0, u_ptr_q} + 13'(U_DEPTH) - back_k;
    if (t >= 13'(U_DEPTH)) begin
      t = t - 13'(U_DEPTH);
    end
    u_raddr = t[UA_W-1:0];
  end

  always_comb begin
    vsum = {1'b0, v_ptr_q} + 12'(V_DEPTH) - {1'b0, w_eff};
    if (vsum >= 12'(V_DEPTH)) begin
      vsum = vsum - 12'(V_DEPTH);
    end
    v_raddr = vsum[VA_W-1:0];
  end

  assign u_we    = (state_q == ST_BUSY) && (step_q == 4'd0);
  assign v_we    = (state_q == ST_CLEAR) || u_we;
  assign v_waddr = (state_q == ST_CLEAR) ? clr_q : v_ptr_q;
  assign v_wdata = (state_q == ST_CLEAR) ? 17'd0 : {!bub_q, vin_q};

  bems_ram #(.WIDTH(16), .DEPTH(U_DEPTH)) u_excite_ram (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_ptr_q),
    .wdata_i (uin_q),
    .raddr_i (u_raddr),
    .rdata_o (u_rdata)
  );

  bems_ram #(.WIDTH(17), .DEPTH(V_DEPTH)) u_recover_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  assign west  = (col_q != '0) ? wr_q : c_q;
  assign east  = ({1'b0, col_q} < w_eff - 11'd1) ? er_q : c_q;
  assign north = (orow != '0) ? u_rdata : c_q;
  assign south = (orow < h_eff - 11'd1) ? uin_q : c_q;

  always_comb begin
    case (step_q)
      4'd5: begin
        ma = 24'({1'b0, v_q} + {1'b0, thr_off_q});
        mb = 24'(thr_scale_q);
      end
      4'd6: begin
        ma = 24'(c_q);
        mb = 24'(UNIT - {1'b0, c_q});
      end
      4'd7: begin
        ma = 24'(ns_q);
        mb = 24'(vert_wt_q);
      end
      4'd8: begin
        ma = p_q[23:0];
        mb = 24'($signed({12'd0, c_q}) - th_q);
      end
      4'd9: begin
        ma = 24'($signed({1'b0, c_q}) - $signed({1'b0, v_q}));
        mb = 24'(recov_gain_q);
      end
      4'd10: begin
        ma = f_q[23:0];
        mb = 24'(react_gain_q);
      end
      4'd11: begin
        ma = 24'($signed(28'(ew_q)) + lv_q);
        mb = 24'(diff_gain_q);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod_d = 48'(ma) * 48'(mb);
    diff   = 28'(rshr(prod_q, 1'b1));
    u_sum  = $signed({12'd0, c_q}) + react_q + diff;
    v_sum  = $signed({12'd0, v_q}) + vd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      step_q        <= '0;
      clr_q         <= '0;
      gw_q          <= RST_GRID_WIDTH;
      gh_q          <= RST_GRID_HEIGHT;
      thr_off_q     <= RST_THR_OFFSET;
      thr_scale_q   <= RST_THR_SCALE;
      react_gain_q  <= RST_REACT_GAIN;
      diff_gain_q   <= RST_DIFF_GAIN;
      vert_wt_q     <= RST_VERT_WEIGHT;
      recov_gain_q  <= RST_RECOV_GAIN;
      u_ptr_q       <= '0;
      v_ptr_q       <= '0;
      col_q         <= '0;
      row_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (!(state_q == ST_BUSY && step_q == STEP_LAST)) begin
        prod_q <= prod_d;
      end
      if (out_valid_q && !out_stall_i && !res_load) begin
        out_valid_q <= 1'b0;
      end
      if (geo_we) begin
        col_q   <= '0;
        row_q   <= '0;
        clr_q   <= '0;
        state_q <= ST_CLEAR;
      end else begin
        case (state_q)
          ST_CLEAR: begin
            if (clr_q == VA_W'(V_DEPTH - 1)) begin
              state_q <= ST_IDLE;
            end else begin
              clr_q <= clr_q + VA_W'(1);
            end
          end
          ST_IDLE: begin
            if (in_acc) begin
              state_q <= ST_BUSY;
              step_q  <= '0;
              bub_q   <= req_type_i;
              uin_q   <= req_type_i ? 16'd0 : u_sat;
              vin_q   <= req_type_i ? 16'd0 : v_sat;
              u_ptr_q <= (u_ptr_q == UA_W'(U_DEPTH - 1)) ? '0 : u_ptr_q + UA_W'(1);
              v_ptr_q <= (v_ptr_q == VA_W'(V_DEPTH - 1)) ? '0 : v_ptr_q + VA_W'(1);
            end
          end
          ST_BUSY: begin
            if (step_q != STEP_LAST) begin
              step_q <= step_q + 4'd1;
            end
            case (step_q)
              4'd1: begin
                v_q     <= v_rdata[15:0];
                valid_q <= v_rdata[16];
              end
              4'd2: c_q  <= u_rdata;
              4'd3: wr_q <= u_rdata;
              4'd4: er_q <= u_rdata;
              4'd5: begin
                ew_q <= $signed({3'd0, east}) + $signed({3'd0, west})
                        - $signed({2'd0, c_q, 1'b0});
                ns_q <= $signed({3'd0, north}) + $signed({3'd0, south})
                        - $signed({2'd0, c_q, 1'b0});
              end
              4'd6:  th_q    <= 28'(rshr(prod_q, 1'b1));
              4'd7:  p_q     <= 28'(rshr(prod_q, 1'b0));
              4'd8:  lv_q    <= 28'(rshr(prod_q, 1'b1));
              4'd9:  f_q     <= 28'(rshr(prod_q, 1'b0));
              4'd10: vd_q    <= 28'(rshr(prod_q, 1'b1));
              4'd11: react_q <= 28'(rshr(prod_q, 1'b1));
              STEP_LAST: begin
                if (out_free) begin
                  state_q <= ST_IDLE;
                  if (valid_q) begin
                    out_valid_q   <= 1'b1;
                    excite_out_q  <= clamp_unit(u_sum);
                    recover_out_q <= clamp_unit(v_sum);
                    frame_last_q  <= ({1'b0, col_q} == w_eff - 11'd1)
                                     && (orow == h_eff - 11'd1);
                  end
                  if ({1'b0, col_q} + 11'd1 >= w_eff) begin
                    col_q <= '0;
                    if ({1'b0, row_q} + 11'd1 >= h_eff) begin
                      row_q <= '0;
                    end else begin
                      row_q <= row_q + POS_W'(1);
                    end
                  end else begin
                    col_q <= col_q + POS_W'(1);
                  end
                end
              end
              default: ;
            endcase
          end
          default: state_q <= ST_CLEAR;
        endcase
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GRID_WIDTH:       gw_q         <= cfg_wdata_i[GEO_W-1:0];
          CFG_GRID_HEIGHT:      gh_q         <= cfg_wdata_i[GEO_W-1:0];
          CFG_THRESHOLD_OFFSET: thr_off_q    <= cfg_wdata_i[15:0];
          CFG_THRESHOLD_SCALE:  thr_scale_q  <= cfg_wdata_i;
          CFG_REACTION_GAIN:    react_gain_q <= cfg_wdata_i;
          CFG_DIFFUSION_GAIN:   diff_gain_q  <= cfg_wdata_i;
          CFG_VERTICAL_WEIGHT:  vert_wt_q    <= cfg_wdata_i;
          CFG_RECOVERY_GAIN:    recov_gain_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign excite_out_o  = excite_out_q;
  assign recover_out_o = recover_out_q;
  assign frame_last_o  = frame_last_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !cfg_we_i |=> state_q == ST_BUSY && step_q == 4'd0)
    else $error("accepted item did not start processing");

  a_result_from_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_BUSY && step_q == STEP_LAST))
    else $error("result appeared outside the final step");

  a_geometry_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == CFG_GRID_WIDTH || cfg_idx_i == CFG_GRID_HEIGHT)
    |=> state_q == ST_CLEAR && clr_q == '0)
    else $error("geometry write did not restart the clearing pass");

endmodule
